### hdl/chained_hash_set_defines.svh
// Assertion macros for the chained hash set
`ifndef CHAINED_HASH_SET_DEFINES_SVH
`define CHAINED_HASH_SET_DEFINES_SVH
`ifndef SYNTHESIS
`define CHS_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("label");
`define CHS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("label");
`else
`define CHS_ASSERT_IMPL(label, clk, rst, a, c)
`define CHS_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### hdl/chs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package chs_pkg;
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam int KeyW = 31;
  localparam int CfgW = 6;
  localparam logic [CfgW-1:0] BucketReset = 6'd20;
endpackage
`default_nettype wire

### hdl/chs_mod.sv
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_set_defines.svh"
// Shift-subtract remainder, one quotient bit per cycle.
module chs_mod #(
  parameter int BW = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [chs_pkg::KeyW-1:0] key,
  input  wire logic [BW:0]              divisor,
  output logic                          done,
  output logic [BW-1:0]                 rem
);
  localparam int CntW = $clog2(chs_pkg::KeyW + 1);
  logic [chs_pkg::KeyW-1:0] shreg;
  logic [BW+1:0] acc;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [BW+1:0] trial;

  always_comb begin
    trial = {acc[BW:0], shreg[chs_pkg::KeyW-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        shreg <= key;
        acc <= '0;
        cnt <= CntW'(chs_pkg::KeyW);
      end else if (busy) begin
        shreg <= shreg << 1;
        if (trial >= {1'b0, divisor}) acc <= trial - {1'b0, divisor};
        else acc <= trial;
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rem = acc[BW-1:0];

  `CHS_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `CHS_ASSERT_IMPL(a_rem_below, clk, rst, done, {2'b0, rem} < {1'b0, divisor})
  `CHS_ASSERT_IMPL(a_no_restart, clk, rst, busy, !start)
endmodule
`default_nettype wire

### hdl/chained_hash_set.sv
// channel  | handshake           | payload
// cfg      | cfg_valid/cfg_ready | cfg_data (bucket_count)
// in       | in_valid/in_ready   | opcode, key
// out      | out_valid/out_ready | found, status, element_count
// An item runs the bit-serial remainder, then reads its bucket head, then walks the
// chain with a read and a compare per node visited (S_RD, S_CHK), up to POOL_NODES
// nodes; an insert first takes its free node. The single-port node memories set
// this walk. out_valid is registered in S_DONE once the walk ends.
// Reset (rst, synchronous) empties every bucket and rebuilds the free list
// node by node in S_INIT; no item is taken meanwhile.
// in_ready is low while an item is at work or its result waits on out_ready.
`timescale 1ns / 1ps
`default_nettype none
`include "chained_hash_set_defines.svh"
module chained_hash_set #(
  parameter int MAX_BUCKETS = 32,
  parameter int POOL_NODES = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [chs_pkg::CfgW-1:0]    cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  opcode,
  input  wire logic [chs_pkg::KeyW-1:0]    key,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             found,
  output logic [1:0]                       status,
  output logic [6:0]                       element_count
);
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = $clog2(POOL_NODES);
  localparam int LW = NW + 1;
  localparam int SW = $clog2(POOL_NODES + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_MOD, S_HEAD, S_RD, S_CHK, S_DONE
  } state_t;
  state_t state;

  logic [chs_pkg::CfgW-1:0] bucket_count;
  logic [LW-1:0] heads [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] head_ok;
  logic [chs_pkg::KeyW-1:0] nkeys [POOL_NODES];
  logic [LW-1:0] nlinks [POOL_NODES];
  logic [chs_pkg::KeyW-1:0] rd_key;
  logic [LW-1:0] rd_link;
  logic [LW-1:0] free_head, cur, prev, nn;
  logic [6:0] cnt;
  logic [SW-1:0] steps;
  logic [NW-1:0] init_idx;
  logic [1:0] op;
  logic [chs_pkg::KeyW-1:0] k;
  logic [BW-1:0] bkt;
  logic [BW:0] divisor;
  logic mod_start, mod_done;
  logic [BW-1:0] rem;
  logic [LW-1:0] head_val;
  // node memory port
  logic mem_we;
  logic [NW-1:0] mem_addr;
  logic [LW-1:0] mem_wlink;
  logic key_we;

  always_comb begin
    if (bucket_count == '0) divisor = (BW+1)'(1);
    else if (32'(bucket_count) > MAX_BUCKETS) divisor = (BW+1)'(MAX_BUCKETS);
    else divisor = (BW+1)'(bucket_count);
    head_val = head_ok[bkt] ? heads[bkt] : NIL;
  end

  // remainder starts on the accepting edge, so it takes the key straight from the port
  chs_mod #(.BW(BW)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .key(key), .divisor(divisor),
    .done(mod_done), .rem(rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) nlinks[mem_addr] <= mem_wlink;
    if (key_we) nkeys[mem_addr] <= k;
    rd_key <= nkeys[mem_addr];
    rd_link <= nlinks[mem_addr];
  end

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    mem_we = 1'b0;
    key_we = 1'b0;
    mem_addr = cur[NW-1:0];
    mem_wlink = NIL;
    mod_start = 1'b0;
    unique case (state)
      S_INIT: begin
        mem_we = 1'b1;
        mem_addr = init_idx;
        mem_wlink = LW'(init_idx) + 1'b1;
      end
      S_IDLE: mod_start = in_valid;
      S_HEAD: begin
        if (op == chs_pkg::OP_INSERT && free_head != NIL) begin
          mem_addr = free_head[NW-1:0];
        end
      end
      S_CHK: begin
        if (op == chs_pkg::OP_INSERT) begin
          if (rd_link == NIL || !(rd_link < NIL) || steps == SW'(POOL_NODES)) begin
            mem_we = 1'b1;
            mem_addr = cur[NW-1:0];
            mem_wlink = nn;
          end
        end else if (rd_key == k && op == chs_pkg::OP_REMOVE) begin
          mem_we = 1'b1;
          mem_addr = cur[NW-1:0];
          mem_wlink = free_head;
        end
      end
      S_DONE: begin
        // write once, on the first cycle; rd_link is re-read afterwards
        if (!out_valid && op == chs_pkg::OP_INSERT && nn != NIL &&
            status == chs_pkg::ST_OK) begin
          mem_we = 1'b1;
          key_we = 1'b1;
          mem_addr = nn[NW-1:0];
          mem_wlink = NIL;
        end else if (!out_valid && op == chs_pkg::OP_REMOVE && found && prev != NIL) begin
          mem_we = 1'b1;
          mem_addr = prev[NW-1:0];
          mem_wlink = rd_link;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_idx <= '0;
      head_ok <= '0;
      bucket_count <= chs_pkg::BucketReset;
      free_head <= '0;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) bucket_count <= cfg_data;
      unique case (state)
        S_INIT: begin
          init_idx <= init_idx + 1'b1;
          if (init_idx == NW'(POOL_NODES - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          op <= opcode;
          k <= key;
          state <= S_MOD;
        end
        S_MOD: if (mod_done) begin
          bkt <= rem;
          state <= S_HEAD;
        end
        S_HEAD: begin
          found <= 1'b0;
          status <= chs_pkg::ST_OK;
          prev <= NIL;
          steps <= '0;
          nn <= NIL;
          if (op == chs_pkg::OP_INSERT) begin
            if (free_head == NIL) begin
              status <= chs_pkg::ST_FULL;
              state <= S_DONE;
            end else begin
              nn <= free_head;
              cur <= free_head;
              state <= S_RD;
            end
          end else if (op == chs_pkg::OP_NONE || head_val == NIL) begin
            if (op == chs_pkg::OP_REMOVE) status <= chs_pkg::ST_NOT_FOUND;
            state <= S_DONE;
          end else begin
            cur <= head_val;
            state <= S_RD;
          end
        end
        S_RD: begin
          // insert: rd_link holds the free node's link, read in S_HEAD
          if (op == chs_pkg::OP_INSERT && cur == nn && steps == '0 &&
              free_head == nn) begin
            free_head <= rd_link;
            if (head_val == NIL) begin
              heads[bkt] <= nn;
              head_ok[bkt] <= 1'b1;
              state <= S_DONE;
            end else begin
              cur <= head_val;
              steps <= SW'(1);
            end
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (op == chs_pkg::OP_INSERT) begin
            if (rd_link == NIL || !(rd_link < NIL) || steps == SW'(POOL_NODES)) begin
              state <= S_DONE;
            end else begin
              cur <= rd_link;
              steps <= steps + 1'b1;
              state <= S_RD;
            end
          end else if (rd_key == k) begin
            found <= 1'b1;
            if (op == chs_pkg::OP_REMOVE) begin
              free_head <= cur;
              if (prev == NIL) begin
                heads[bkt] <= rd_link;
                head_ok[bkt] <= 1'b1;
              end
            end
            state <= S_DONE;
          end else if (!(rd_link < NIL) || steps == SW'(POOL_NODES - 1)) begin
            if (op == chs_pkg::OP_REMOVE) status <= chs_pkg::ST_NOT_FOUND;
            state <= S_DONE;
          end else begin
            prev <= cur;
            cur <= rd_link;
            steps <= steps + 1'b1;
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            if (op == chs_pkg::OP_INSERT && status == chs_pkg::ST_OK) cnt <= cnt + 1'b1;
            if (op == chs_pkg::OP_REMOVE && found && cnt != '0) cnt <= cnt - 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
  assign element_count = cnt;

  `CHS_ASSERT_IMPL(a_busy_not_ready, clk, rst, out_valid, !in_ready)
  `CHS_ASSERT_IMPL(a_cnt_bound, clk, rst, 1'b1, 32'(cnt) <= POOL_NODES)
  `CHS_ASSERT_IMPL(a_full_no_free, clk, rst, out_valid && status == chs_pkg::ST_FULL,
                   free_head == NIL)
  `CHS_ASSERT_IMPL(a_found_not_ins, clk, rst, out_valid && op == chs_pkg::OP_INSERT, !found)
endmodule
`default_nettype wire
